>>> rtl/sioq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioq_pkg: shared types and constants for the sorted I/O request queue
// Payload structs, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sioq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned OccW       = $clog2(QueueDepth + 1);
  localparam int unsigned SlotW      = 6;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_MERGE  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_BACK     = 3'd1,
    ST_FRONT    = 3'd2,
    ST_NOMERGE  = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_READ_LAT  = 2'd0,
    CFG_WRITE_LAT = 2'd1,
    CFG_MAX_SECT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  device;
    logic [31:0] start_sector;
    logic [15:0] sector_count;
    logic        is_write;
    logic        locked;
    logic        skip_first;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [7:0]  out_device;
    logic [31:0] out_sector;
    logic [15:0] out_count;
    logic        out_is_write;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] sector;
    logic [15:0] count;
    logic        is_write;
    logic        locked;
    logic [15:0] budget;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_MRG_RD,
    S_MRG_CHK,
    S_AGE_RD,
    S_AGE_WR,
    S_MRG_WR,
    S_REM_RD,
    S_REM_WR,
    S_OUT
  } state_e;

  // Datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,     // capture request and start scan pointer
    OP_RD,        // issue read of entry at pointer
    OP_INS_STEP,  // insert scan: pass entry (age it) and step down
    OP_INS_STOP,  // insert scan: stop, place at pointer
    OP_SHIFT_UP,  // write entry read from pointer-1 to pointer, step down
    OP_INS_PUT,   // write new entry at place
    OP_MRG_STEP,  // merge scan: skip entry, step down
    OP_MRG_HIT,   // merge scan: record hit
    OP_AGE,       // write aged entry at pointer, step up
    OP_MRG_PUT,   // write merged entry at hit
    OP_REM_DOWN,  // write read entry to pointer-1, step up
    OP_RESULT     // load result register
  } op_e;

  typedef struct packed {
    op_e        op;
    status_e    status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e       cmd;
    logic       full;       // occupancy at depth
    logic       empty;
    logic       at_low;     // scan pointer reached lower bound
    logic       at_top;     // up-scan pointer reached occupancy
    logic       shift_done; // shift pointer reached place
    logic       ins_stop;   // read entry stops insert scan
    logic       mrg_skip;   // read entry not a candidate
    logic       mrg_back;   // back adjacency hit
    logic       mrg_abort;  // candidate with spent budget
    logic       mrg_front;  // front adjacency hit
    logic       hit_front;  // recorded hit was a front merge
    logic       out_free;   // result register empty or draining
  } dp_status_t;

endpackage

>>> rtl/sioq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioq_ctrl: operation sequencer
// Walks one command through read/check/write steps over the entry memory.
// ----------------------------------------------------------------------------
module sioq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_fire_i,
  input  sioq_pkg::dp_status_t  sts_i,
  output logic                  in_ready_o,
  output sioq_pkg::dp_cmd_t     cmd_o
);
  import sioq_pkg::*;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_d       = state_q;
    res_d         = res_q;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_INS_RD;
        end
      end
      // Dispatch happens in the cycle after latch (cmd visible in status)
      S_INS_RD: begin
        unique case (sts_i.cmd)
          CMD_INSERT: begin
            if (sts_i.full) begin
              res_d = ST_EMPTY; state_d = S_OUT;
            end else if (sts_i.at_low) begin
              cmd_o.op = OP_INS_STOP; state_d = S_SHIFT_RD;
            end else begin
              cmd_o.op = OP_RD; state_d = S_INS_CHK;
            end
          end
          CMD_MERGE: begin
            if (sts_i.at_low) begin
              res_d = ST_NOMERGE; state_d = S_OUT;
            end else begin
              cmd_o.op = OP_RD; state_d = S_MRG_CHK;
            end
          end
          CMD_REMOVE: begin
            if (sts_i.empty) begin
              res_d = ST_EMPTY; state_d = S_OUT;
            end else begin
              cmd_o.op = OP_RD; state_d = S_REM_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.ins_stop) begin
          cmd_o.op = OP_INS_STOP; state_d = S_SHIFT_RD;
        end else begin
          cmd_o.op = OP_INS_STEP; state_d = S_INS_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_done) begin
          state_d = S_INS_WR;
        end else begin
          cmd_o.op = OP_RD; state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.op = OP_SHIFT_UP; state_d = S_SHIFT_RD;
      end
      S_INS_WR: begin
        cmd_o.op = OP_INS_PUT; res_d = ST_INSERTED; state_d = S_OUT;
      end
      S_MRG_RD: begin
        if (sts_i.at_low) begin
          res_d = ST_NOMERGE; state_d = S_OUT;
        end else begin
          cmd_o.op = OP_RD; state_d = S_MRG_CHK;
        end
      end
      S_MRG_CHK: begin
        if (sts_i.mrg_skip) begin
          cmd_o.op = OP_MRG_STEP; state_d = S_MRG_RD;
        end else if (sts_i.mrg_back) begin
          cmd_o.op = OP_MRG_HIT; state_d = S_AGE_RD;
        end else if (sts_i.mrg_abort) begin
          res_d = ST_NOMERGE; state_d = S_OUT;
        end else if (sts_i.mrg_front) begin
          cmd_o.op = OP_MRG_HIT; state_d = S_AGE_RD;
        end else begin
          cmd_o.op = OP_MRG_STEP; state_d = S_MRG_RD;
        end
      end
      S_AGE_RD: begin
        if (sts_i.at_top) begin
          cmd_o.op = OP_RD; state_d = S_MRG_WR;
        end else begin
          cmd_o.op = OP_RD; state_d = S_AGE_WR;
        end
      end
      S_AGE_WR: begin
        cmd_o.op = OP_AGE; state_d = S_AGE_RD;
      end
      S_MRG_WR: begin
        cmd_o.op = OP_MRG_PUT;
        res_d    = sts_i.hit_front ? ST_FRONT : ST_BACK;
        state_d  = S_OUT;
      end
      S_REM_RD: begin
        // result comes from the head copy of slot 0; read and shift the rest down
        if (sts_i.at_top) begin
          res_d = ST_REMOVED; state_d = S_OUT;
        end else begin
          cmd_o.op = OP_RD; state_d = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd_o.op = OP_REM_DOWN; state_d = S_REM_RD;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_RESULT; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ap_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.op == OP_RESULT |-> state_q == S_OUT)
    else $error("result loaded outside output state");
  ap_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_fire_i |-> state_q == S_IDLE)
    else $error("transaction accepted while busy");
  ap_out_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.op == OP_RESULT |=> state_q == S_IDLE)
    else $error("no return to idle after result");

endmodule

>>> rtl/sioq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sioq_dp: queue datapath
// Entry memory (one write, one registered read port), scan pointers,
// compare logic, occupancy, configuration and the result register.
// ----------------------------------------------------------------------------
module sioq_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sioq_pkg::req_t        req_i,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  sioq_pkg::dp_cmd_t     cmd_i,
  output sioq_pkg::dp_status_t  sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sioq_pkg::rsp_t        out_data_o
);
  import sioq_pkg::*;

  entry_t mem [QueueDepth];
  entry_t rd_q;

  req_t          req_q;
  logic [OccW-1:0] occ_q, occ_d;
  logic [OccW-1:0] ptr_q, ptr_d;   // scan pointer
  logic [OccW-1:0] pos_q, pos_d;   // insert place or merge hit
  logic [OccW-1:0] low_q, low_d;
  logic          front_q, front_d;
  logic          age_q, age_d;     // merge is in its aging pass
  logic [15:0]   rlat_q, wlat_q, maxs_q;
  logic          out_valid_q;
  rsp_t          out_q, out_d;

  logic          we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t        wdata;

  // Hit entry copy (merge), written entry copy and head copy (remove)
  entry_t mem_hit_q;
  entry_t put_q;
  entry_t head_q;
  logic   head_cap_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlat_q <= 16'd128;
      wlat_q <= 16'd512;
      maxs_q <= 16'd255;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_READ_LAT:  rlat_q <= cfg_data_i;
        CFG_WRITE_LAT: wlat_q <= cfg_data_i;
        CFG_MAX_SECT:  maxs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Compare logic on the entry just read
  logic [16:0] sum_cnt;
  logic        ordered;
  assign sum_cnt = {1'b0, rd_q.count} + {1'b0, req_q.sector_count};
  assign ordered = (rd_q.device < req_q.device) ||
                   (rd_q.device == req_q.device && rd_q.sector < req_q.start_sector);

  always_comb begin
    sts_o.cmd        = cmd_e'(req_q.cmd);
    sts_o.full       = (occ_q == OccW'(QueueDepth));
    sts_o.empty      = (occ_q == '0);
    sts_o.at_low     = (ptr_q == low_q);
    sts_o.at_top     = (ptr_q == occ_q);
    sts_o.shift_done = (ptr_q == pos_q);
    sts_o.ins_stop   = ordered || (rd_q.budget == '0);
    sts_o.mrg_skip   = rd_q.locked || (rd_q.is_write != req_q.is_write) ||
                       (sum_cnt > {1'b0, maxs_q}) || (rd_q.device != req_q.device);
    sts_o.mrg_back   = (rd_q.sector + 32'(rd_q.count)) == req_q.start_sector;
    sts_o.mrg_abort  = (rd_q.budget == '0);
    sts_o.mrg_front  = (rd_q.sector - 32'(req_q.sector_count)) == req_q.start_sector;
    sts_o.hit_front  = front_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Pointers, memory port control
  always_comb begin
    ptr_d   = ptr_q;
    pos_d   = pos_q;
    low_d   = low_q;
    occ_d   = occ_q;
    front_d = front_q;
    age_d   = age_q;
    we      = 1'b0;
    waddr   = ptr_q[IdxW-1:0];
    wdata   = rd_q;
    raddr   = ptr_q[IdxW-1:0];
    unique case (cmd_i.op)
      OP_LATCH: begin
        ptr_d   = (cmd_e'(req_i.cmd) == CMD_REMOVE) ? OccW'(1) : occ_q;
        low_d   = (req_i.skip_first && occ_q != '0) ? OccW'(1) : '0;
        pos_d   = low_d;
        front_d = 1'b0;
        age_d   = 1'b0;
      end
      OP_RD: begin
        // insert and merge scans read below the pointer; shift too.
        // aging and remove read at it
        raddr = ptr_q[IdxW-1:0];
        if (ptr_q != '0 && (req_q.cmd == CMD_INSERT ||
            (req_q.cmd == CMD_MERGE && !age_q))) begin
          raddr = IdxW'(ptr_q - 1'b1);
        end
      end
      OP_INS_STEP: begin
        we           = 1'b1;
        waddr        = IdxW'(ptr_q - 1'b1);
        wdata.budget = rd_q.budget - 1'b1;
        ptr_d        = ptr_q - 1'b1;
      end
      OP_INS_STOP: begin
        pos_d = ptr_q;
        ptr_d = occ_q;
      end
      OP_SHIFT_UP: begin
        we    = 1'b1;
        waddr = ptr_q[IdxW-1:0];
        ptr_d = ptr_q - 1'b1;
      end
      OP_INS_PUT: begin
        we             = 1'b1;
        waddr          = pos_q[IdxW-1:0];
        wdata.device   = req_q.device;
        wdata.sector   = req_q.start_sector;
        wdata.count    = req_q.sector_count;
        wdata.is_write = req_q.is_write;
        wdata.locked   = req_q.locked;
        wdata.budget   = req_q.is_write ? wlat_q : rlat_q;
        occ_d          = occ_q + 1'b1;
      end
      OP_MRG_STEP: ptr_d = ptr_q - 1'b1;
      OP_MRG_HIT: begin
        pos_d   = ptr_q - 1'b1;
        front_d = !sts_o.mrg_back;
        age_d   = 1'b1;
        ptr_d   = ptr_q;  // first entry behind the hit
      end
      OP_AGE: begin
        we    = 1'b1;
        waddr = ptr_q[IdxW-1:0];
        if (rd_q.budget != '0) wdata.budget = rd_q.budget - 1'b1;
        ptr_d = ptr_q + 1'b1;
      end
      OP_MRG_PUT: begin
        we          = 1'b1;
        waddr       = pos_q[IdxW-1:0];
        wdata       = mem_hit_q;
        wdata.count = mem_hit_q.count + req_q.sector_count;
        if (front_q) begin
          wdata.sector = req_q.start_sector;
          wdata.budget = mem_hit_q.budget - 1'b1;
        end
      end
      OP_REM_DOWN: begin
        we    = 1'b1;
        waddr = IdxW'(ptr_q - 1'b1);
        ptr_d = ptr_q + 1'b1;
      end
      OP_RESULT: begin
        if (req_q.cmd == CMD_REMOVE && cmd_i.status == ST_REMOVED) begin
          occ_d = occ_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Copies of the hit entry and of the written entry for the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MRG_HIT) mem_hit_q <= rd_q;
    if (cmd_i.op == OP_MRG_PUT || cmd_i.op == OP_INS_PUT) put_q <= wdata;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      ptr_q   <= '0;
      pos_q   <= '0;
      low_q   <= '0;
      front_q <= 1'b0;
      age_q   <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      pos_q   <= pos_d;
      low_q   <= low_d;
      occ_q   <= occ_d;
      front_q <= front_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) req_q <= req_i;
  end

  // Head entry captured before the down-shift overwrites slot 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) head_cap_q <= 1'b0;
    else head_cap_q <= (cmd_i.op == OP_LATCH && cmd_e'(req_i.cmd) == CMD_REMOVE);
  end
  always_ff @(posedge clk_i) begin
    if (head_cap_q) head_q <= mem[0];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESULT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d        = '0;
    out_d.status = cmd_i.status;
    unique case (cmd_i.status)
      ST_INSERTED, ST_BACK, ST_FRONT: begin
        out_d.slot         = SlotW'(pos_q);
        out_d.out_device   = put_q.device;
        out_d.out_sector   = put_q.sector;
        out_d.out_count    = put_q.count;
        out_d.out_is_write = put_q.is_write;
      end
      ST_REMOVED: begin
        out_d.out_device   = head_q.device;
        out_d.out_sector   = head_q.sector;
        out_d.out_count    = head_q.count;
        out_d.out_is_write = head_q.is_write;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESULT) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ap_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      occ_q <= OccW'(QueueDepth))
    else $error("occupancy beyond depth");
  ap_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && out_stall_i |-> cmd_i.op != OP_RESULT)
    else $error("result overwritten while stalled");
  ap_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.op == OP_INS_PUT |=> occ_q == $past(occ_q) + 1'b1)
    else $error("insert did not grow occupancy");

endmodule

>>> rtl/sorted_io_queue_with_aging_and_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_io_queue_with_aging_and_merge: sorted block I/O request queue
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | sioq_pkg::req_t
//   out     | output    | out_valid_o / out_stall_i| sioq_pkg::rsp_t
//   cfg     | input     | cfg_valid_i / cfg_ready_o| index 2b, data 16b
//
// One transaction at a time. Insert reads and checks each entry scanned,
// then reads and writes each entry shifted; merge reads and checks each
// entry scanned, then reads and writes each entry aged; remove reads and
// writes each entry moved; all steps share the entry memory's one write
// and one read port. Reset clears occupancy and control; entry contents
// stay undefined until written. A stalled result holds while the next
// transaction is already accepted and worked on.
// ----------------------------------------------------------------------------
module sorted_io_queue_with_aging_and_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sioq_pkg::req_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sioq_pkg::rsp_t    out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import sioq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  logic       ready;

  assign in_stall_o  = !ready;
  assign cfg_ready_o = 1'b1;

  sioq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_valid_i && ready),
    .sts_i      (sts),
    .in_ready_o (ready),
    .cmd_o      (cmd)
  );

  sioq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
